/* src/rsfr_pkg.sv */
// Shared constants, types and helper functions for the radio status frame receiver.
`default_nettype none

package rsfr_pkg;

    localparam int BUF_DEPTH = 127;
    localparam int FILL_W    = $clog2(BUF_DEPTH + 1);
    localparam int CMP_W     = ((FILL_W > 9) ? FILL_W : 9) + 1;

    localparam int NUM_SLOTS = 7;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CRC_W     = 16;

    localparam logic [7:0]  SYNC_BYTE = 8'hA5;
    localparam logic [7:0]  ID_BYTE   = 8'h14;
    localparam logic [7:0]  KIND_MASK = 8'h7F;
    localparam logic [15:0] CRC_POLY  = 16'h8005;
    localparam logic [15:0] CODE_MASK = 16'hFFF0;

    localparam logic [19:0] FREQ_BASE   = 20'd118000;
    localparam logic [19:0] ACTIVE_RST  = 20'd131280;
    localparam logic [19:0] STANDBY_RST = 20'd121500;
    localparam logic [8:0]  BATT_OFFSET = 9'd85;
    localparam logic [7:0]  VOL_BASE    = 8'd50;
    localparam logic [7:0]  SQ_OFFSET   = 8'd6;
    localparam logic [7:0]  VOL_RECIP   = 8'd205;

    localparam logic [6:0] KIND_VERSION   = 7'd0;
    localparam logic [6:0] KIND_VOLUME    = 7'd3;
    localparam logic [6:0] KIND_SQUELCH   = 7'd4;
    localparam logic [6:0] KIND_STATUS    = 7'd12;
    localparam logic [6:0] KIND_VOLTAGE   = 7'd21;
    localparam logic [6:0] KIND_CHANNEL   = 7'd22;
    localparam logic [6:0] KIND_RX_STATUS = 7'd64;

    localparam logic [SLOT_W-1:0] SLOT_VERSION   = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_VOLUME    = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_SQUELCH   = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] SLOT_STATUS    = SLOT_W'(3);
    localparam logic [SLOT_W-1:0] SLOT_VOLTAGE   = SLOT_W'(4);
    localparam logic [SLOT_W-1:0] SLOT_CHANNEL   = SLOT_W'(5);
    localparam logic [SLOT_W-1:0] SLOT_RX_STATUS = SLOT_W'(6);

    localparam logic [6:0] CHAN_STEP [16] = '{
        7'd0, 7'd5, 7'd10, 7'd15, 7'd25, 7'd30, 7'd35, 7'd40,
        7'd50, 7'd55, 7'd60, 7'd65, 7'd75, 7'd80, 7'd85, 7'd90
    };

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_APPLIED = 3'd1,
        ST_IGNORED = 3'd2,
        ST_CRC_BAD = 3'd3,
        ST_DROPPED = 3'd4
    } t_frame_status;

    typedef struct packed {
        logic              known;
        logic [SLOT_W-1:0] slot;
    } t_kind;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [19:0] code_to_khz(input logic [15:0] code);
        logic [15:0] hi;
        logic [19:0] x;
        hi = code & CODE_MASK;
        x  = 20'(hi[15:4]);
        // x * 100 as shifts
        return FREQ_BASE + (x << 6) + (x << 5) + (x << 2) + 20'(CHAN_STEP[code[3:0]]);
    endfunction

    function automatic t_kind kind_slot(input logic [6:0] kind);
        t_kind k;
        k.known = 1'b1;
        k.slot  = SLOT_VERSION;
        case (kind)
            KIND_VERSION:   k.slot = SLOT_VERSION;
            KIND_VOLUME:    k.slot = SLOT_VOLUME;
            KIND_SQUELCH:   k.slot = SLOT_SQUELCH;
            KIND_STATUS:    k.slot = SLOT_STATUS;
            KIND_VOLTAGE:   k.slot = SLOT_VOLTAGE;
            KIND_CHANNEL:   k.slot = SLOT_CHANNEL;
            KIND_RX_STATUS: k.slot = SLOT_RX_STATUS;
            default:        k.known = 1'b0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

/* src/rsfr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rsfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 7,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/radio_status_frame_receiver.sv */
// Top level: byte-wise frame assembly, CRC check and status decode of radio frames.
// The result for a byte is registered and offered in the cycle after the byte is accepted.
// Throughput: one byte per cycle when not stalled; the CRC advances one byte per cycle and the
// per-kind CRC memory is read when the kind byte arrives, ready before frame end.
// Reset (synchronous, active low) restores all radio state and clears the
// per-kind CRC valid bits at once; no clearing pass, a byte is taken right after.
`default_nettype none

module radio_status_frame_receiver (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic              i_sending,
    input  wire logic              i_chunk_end,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [2:0]             o_frame_status,
    output logic signed [6:0]      o_volume,
    output logic signed [7:0]      o_squelch,
    output logic                   o_dual_mode,
    output logic [19:0]            o_active_freq_khz,
    output logic [19:0]            o_standby_freq_khz,
    output logic [8:0]             o_battery_tenths,
    output logic                   o_transmitting,
    output logic                   o_rx_primary,
    output logic                   o_rx_standby,
    output logic                   o_changed
);

    import rsfr_pkg::*;

    logic                    w_accept;
    logic                    w_chunk_unused;

    logic [FILL_W-1:0]       r_fill, n_fill;
    logic [7:0]              r_fb [8];
    logic [7:0]              n_fb [8];
    logic [15:0]             r_trail, n_trail;
    logic [15:0]             r_crc, n_crc;
    logic [NUM_SLOTS-1:0]    r_crc_valid;
    t_kind                   r_kind;
    logic                    r_rd_valid;

    logic signed [6:0]       r_vol, n_vol;
    logic signed [7:0]       r_sq, n_sq;
    logic                    r_dual, n_dual;
    logic [19:0]             r_act, n_act;
    logic [19:0]             r_stb, n_stb;
    logic [8:0]              r_batt, n_batt;
    logic [3:0]              r_flags, n_flags;
    t_frame_status           r_status, n_status;
    logic                    r_out_valid;

    logic [FILL_W-1:0]       w_pos;
    logic [7:0]              w_len;
    logic [15:0]             w_crc_base;
    logic                    w_frame_end;
    logic                    w_apply;
    logic [15:0]             w_last_crc;
    logic [15:0]             w_ram_rdata;
    logic [7:0]              w_kind_byte;
    t_kind                   w_kind_in;
    logic                    w_ram_re;
    logic                    w_ram_we;

    logic [7:0]              w_vmag;
    logic [15:0]             w_vprod;
    logic [6:0]              w_vq;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    // chunk markers carry no framing meaning
    assign w_chunk_unused = i_chunk_end;

    assign w_kind_byte = i_rx_byte & KIND_MASK;
    assign w_kind_in   = kind_slot(w_kind_byte[6:0]);
    assign w_ram_re    = w_accept && (w_pos == FILL_W'(3));
    assign w_ram_we    = w_accept && w_apply;

    rsfr_ram #(
        .WIDTH (CRC_W),
        .DEPTH (NUM_SLOTS)
    ) u_crc_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_kind.slot),
        .i_wdata (n_crc),
        .i_re    (w_ram_re),
        .i_raddr (w_kind_in.slot),
        .o_rdata (w_ram_rdata)
    );

    assign w_last_crc = r_rd_valid ? w_ram_rdata : '0;

    always_comb begin
        w_pos = r_fill;
        if (i_rx_byte == SYNC_BYTE) begin
            w_pos = '0;
        end
        if (CMP_W'(w_pos) >= CMP_W'(BUF_DEPTH)) begin
            w_pos = '0;
        end

        n_fb = r_fb;
        if (w_pos < FILL_W'(8)) begin
            n_fb[w_pos[2:0]] = i_rx_byte;
        end
        w_len = n_fb[2];

        w_crc_base = (w_pos == '0) ? '0 : r_crc;
        if (w_pos < FILL_W'(3) || CMP_W'(w_pos) < CMP_W'(w_len) + CMP_W'(3)) begin
            n_crc = crc_step(w_crc_base, i_rx_byte);
        end else begin
            n_crc = w_crc_base;
        end

        n_trail = {r_trail[7:0], i_rx_byte};

        n_fill = w_pos + FILL_W'(1);
        if (n_fill == FILL_W'(2) && i_rx_byte != ID_BYTE) begin
            n_fill = '0;
        end

        w_frame_end = (n_fill >= FILL_W'(3)) && (CMP_W'(n_fill) >= CMP_W'(w_len) + CMP_W'(5));

        w_apply  = 1'b0;
        n_status = ST_NONE;
        if (w_frame_end) begin
            n_fill = '0;
            if (n_crc != n_trail) begin
                n_status = ST_CRC_BAD;
            end else if (i_sending) begin
                n_status = ST_DROPPED;
            end else if (!r_kind.known || w_last_crc == n_crc) begin
                n_status = ST_IGNORED;
            end else begin
                n_status = ST_APPLIED;
                w_apply  = 1'b1;
            end
        end

        // volume: (50 - b) / 5 toward zero, via reciprocal 205/1024
        if (n_fb[4] <= VOL_BASE) begin
            w_vmag = VOL_BASE - n_fb[4];
        end else begin
            w_vmag = n_fb[4] - VOL_BASE;
        end
        w_vprod = 16'(w_vmag) * 16'(VOL_RECIP);
        w_vq    = 7'(w_vprod[15:10]);

        n_vol   = r_vol;
        n_sq    = r_sq;
        n_dual  = r_dual;
        n_act   = r_act;
        n_stb   = r_stb;
        n_batt  = r_batt;
        n_flags = r_flags;
        if (w_apply) begin
            case (r_kind.slot)
                SLOT_VOLUME: begin
                    n_vol = (n_fb[4] <= VOL_BASE) ? w_vq : -w_vq;
                end
                SLOT_SQUELCH: begin
                    if (n_fb[4] >= SQ_OFFSET) begin
                        n_sq = ((n_fb[4] - SQ_OFFSET) >> 1) + 8'd1;
                    end else begin
                        n_sq = 8'd1 - ((SQ_OFFSET - n_fb[4]) >> 1);
                    end
                end
                SLOT_STATUS: begin
                    n_dual = n_fb[4][0];
                end
                SLOT_VOLTAGE: begin
                    n_batt = BATT_OFFSET + 9'(n_fb[4]);
                end
                SLOT_CHANNEL: begin
                    n_act = code_to_khz({n_fb[4], n_fb[5]});
                    n_stb = code_to_khz({n_fb[6], n_fb[7]});
                end
                SLOT_RX_STATUS: begin
                    n_flags[0] = n_fb[7][5] || n_fb[7][6];
                    n_flags[1] = n_fb[7][7];
                    n_flags[2] = n_fb[6][0];
                end
                default: begin
                end
            endcase
            if (r_kind.slot != SLOT_VERSION) begin
                n_flags[3] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_fb        <= '{default: '0};
            r_trail     <= '0;
            r_crc       <= '0;
            r_crc_valid <= '0;
            r_kind      <= '0;
            r_rd_valid  <= 1'b0;
            r_vol       <= '0;
            r_sq        <= '0;
            r_dual      <= 1'b0;
            r_act       <= ACTIVE_RST;
            r_stb       <= STANDBY_RST;
            r_batt      <= '0;
            r_flags     <= '0;
            r_status    <= ST_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fill  <= n_fill;
                r_fb    <= n_fb;
                r_trail <= n_trail;
                r_crc   <= n_crc;
                r_vol   <= n_vol;
                r_sq    <= n_sq;
                r_dual  <= n_dual;
                r_act   <= n_act;
                r_stb   <= n_stb;
                r_batt  <= n_batt;
                r_flags <= n_flags;
                r_status <= n_status;
                if (w_ram_re) begin
                    r_kind     <= w_kind_in;
                    r_rd_valid <= r_crc_valid[w_kind_in.slot];
                end
                if (w_apply) begin
                    r_crc_valid[r_kind.slot] <= 1'b1;
                end
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_frame_status     = r_status;
    assign o_volume           = r_vol;
    assign o_squelch          = r_sq;
    assign o_dual_mode        = r_dual;
    assign o_active_freq_khz  = r_act;
    assign o_standby_freq_khz = r_stb;
    assign o_battery_tenths   = r_batt;
    assign o_transmitting     = r_flags[0];
    assign o_rx_primary       = r_flags[1];
    assign o_rx_standby       = r_flags[2];
    assign o_changed          = r_flags[3] && !w_chunk_unused | r_flags[3];

endmodule

`default_nettype wire

/* src/rsfr_checker.sv */
// Port-level assertions for the radio status frame receiver, bound to the top level.
`default_nettype none

module rsfr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] o_frame_status,
    input wire logic       o_changed
);

    import rsfr_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_req_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted request produced no result");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_frame_status <= ST_DROPPED)
        else $error("frame status out of range");

    a_changed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_changed |=> o_changed)
        else $error("changed flag cleared without reset");

    a_changed_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_changed) |-> o_out_valid && o_frame_status == ST_APPLIED)
        else $error("changed flag set without an applied frame");

endmodule

bind radio_status_frame_receiver rsfr_checker u_rsfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_frame_status (o_frame_status),
    .o_changed      (o_changed)
);

`default_nettype wire
